/* hw/rtl/lmrp_pkg.sv */
// Shared types and constants for the load-module record parser.
// Used by lmrp_core and load_module_record_parser; depends on nothing else.
`timescale 1ns / 1ps
package lmrp_pkg;

  typedef struct packed {
    logic       file_start;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        bank_select;
    logic [14:0] bank_offset;
    logic [7:0]  write_data;
    logic [15:0] exec_address;
  } out_item_t;

  typedef enum logic [2:0] {
    FS_RUNNING = 3'b001,
    FS_DONE    = 3'b010,
    FS_ERROR   = 3'b100
  } finish_t;

  localparam logic [2:0] ST_HEADER  = 3'd0;
  localparam logic [2:0] ST_WRITE   = 3'd1;
  localparam logic [2:0] ST_EXEC    = 3'd2;
  localparam logic [2:0] ST_LOWADDR = 3'd3;
  localparam logic [2:0] ST_BADTYPE = 3'd4;
  localparam logic [2:0] ST_IGNORED = 3'd5;

  localparam logic [7:0] REC_LOAD = 8'h01;
  localparam logic [7:0] REC_EXEC = 8'h02;
  localparam logic [7:0] REC_SKIP = 8'h03;

  localparam logic [15:0] MIN_LOAD_RESET = 16'h4000;

  localparam logic [0:0] ADDR_MIN_LOAD = 1'd0;

  function automatic logic [8:0] decode_length(input logic [7:0] code);
    logic [8:0] len;
    case (code)
      8'd0:    len = 9'd254;
      8'd1:    len = 9'd255;
      8'd2:    len = 9'd256;
      default: len = {1'b0, code} - 9'd2;
    endcase
    return len;
  endfunction

endpackage

/* hw/rtl/lmrp_core.sv */
// Parser state and per-byte decode for the load-module record parser.
// Depends on lmrp_pkg. State advances on fire; res is the result of item.
`timescale 1ns / 1ps
module lmrp_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  lmrp_pkg::in_item_t  item,
  input  logic [15:0]         min_load_address,
  output lmrp_pkg::out_item_t res
);

  logic                 in_data_phase, in_data_phase_next;
  logic [8:0]           byte_counter, byte_counter_next;
  logic [8:0]           record_length, record_length_next;
  logic [15:0]          load_base, load_base_next;
  logic                 kind_load, kind_load_next;
  lmrp_pkg::finish_t    finish_state, finish_state_next;
  logic [7:0]           hdr0, hdr1, hdr2;

  logic                 phase_eff;
  logic [8:0]           cnt_eff;
  logic                 running;
  logic [8:0]           cnt_inc;
  logic [15:0]          hdr_addr;
  logic [15:0]          wr_addr;

  always_comb begin
    phase_eff = item.file_start ? 1'b0 : in_data_phase;
    cnt_eff   = item.file_start ? 9'd0 : byte_counter;
    running   = item.file_start || (finish_state == lmrp_pkg::FS_RUNNING);
    cnt_inc   = cnt_eff + 9'd1;
    hdr_addr  = {item.data_byte, hdr2};
    wr_addr   = load_base + {7'd0, cnt_eff};

    in_data_phase_next = phase_eff;
    byte_counter_next  = cnt_eff;
    record_length_next = record_length;
    load_base_next     = load_base;
    kind_load_next     = kind_load;
    finish_state_next  = item.file_start ? lmrp_pkg::FS_RUNNING : finish_state;
    res                = '0;
    res.status         = lmrp_pkg::ST_HEADER;

    if (!running) begin
      res.status = lmrp_pkg::ST_IGNORED;
    end else if (!phase_eff) begin
      byte_counter_next = cnt_inc;
      if (cnt_eff[1:0] == 2'd3) begin
        byte_counter_next  = 9'd0;
        record_length_next = lmrp_pkg::decode_length(hdr1);
        kind_load_next     = (hdr0 == lmrp_pkg::REC_LOAD);
        case (hdr0)
          lmrp_pkg::REC_LOAD: begin
            load_base_next = hdr_addr;
            if (hdr_addr < min_load_address) begin
              res.status        = lmrp_pkg::ST_LOWADDR;
              finish_state_next = lmrp_pkg::FS_ERROR;
            end else begin
              in_data_phase_next = 1'b1;
            end
          end
          lmrp_pkg::REC_EXEC: begin
            res.status        = lmrp_pkg::ST_EXEC;
            res.exec_address  = hdr_addr;
            finish_state_next = lmrp_pkg::FS_DONE;
          end
          lmrp_pkg::REC_SKIP: begin
            in_data_phase_next = 1'b1;
          end
          default: begin
            res.status        = lmrp_pkg::ST_BADTYPE;
            finish_state_next = lmrp_pkg::FS_ERROR;
          end
        endcase
      end
    end else begin
      if (kind_load) begin
        res.status      = lmrp_pkg::ST_WRITE;
        res.bank_select = wr_addr[15];
        res.bank_offset = wr_addr[14:0];
        res.write_data  = item.data_byte;
      end
      byte_counter_next = cnt_inc;
      if (cnt_inc >= record_length) begin
        byte_counter_next  = 9'd0;
        in_data_phase_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_data_phase <= 1'b0;
      byte_counter  <= 9'd0;
      record_length <= 9'd0;
      load_base     <= 16'd0;
      kind_load     <= 1'b1;
      finish_state  <= lmrp_pkg::FS_RUNNING;
    end else if (fire) begin
      in_data_phase <= in_data_phase_next;
      byte_counter  <= byte_counter_next;
      record_length <= record_length_next;
      load_base     <= load_base_next;
      kind_load     <= kind_load_next;
      finish_state  <= finish_state_next;
    end
  end

  // header bytes 0..2; byte 3 is taken straight from the item
  always_ff @(posedge clk) begin
    if (fire && running && !phase_eff) begin
      case (cnt_eff[1:0])
        2'd0:    hdr0 <= item.data_byte;
        2'd1:    hdr1 <= item.data_byte;
        2'd2:    hdr2 <= item.data_byte;
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/load_module_record_parser.sv */
// Load-module record parser, top level: input and result registers, APB register.
// Depends on lmrp_pkg and lmrp_core.
//
// Usage:
//   byte_* channel: one file byte per item, file_start marks a new file.
//   res_* channel: exactly one result item per input item, in order.
//   Handshake: an item moves at a rising edge with valid high and stall low.
//   An accepted byte is held in the input register, then in the result register, where it is offered on res_*.
//   Throughput: one byte per cycle while res_stall is low; the record state update is
//   combinational logic between the input register and the result register.
//   Stall: the result register holds its valid result while res_stall is high; the input
//   register takes at most one more byte, and byte_stall is high while it
//   holds a byte behind the waiting result.
//   Reset: both registers empty, parser at the start of a file, min_load_address = 0x4000.
//   The user writes registers only while idle; the block does not enforce it.
//   APB: min_load_address at byte address 0, pready always high.
`timescale 1ns / 1ps
module load_module_record_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  lmrp_pkg::in_item_t  byte_item,
  output logic                res_valid,
  input  logic                res_stall,
  output lmrp_pkg::out_item_t res_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic                a_valid;
  lmrp_pkg::in_item_t  a_item;
  logic                b_ready;
  logic                fire;
  logic [15:0]         min_load_address;
  lmrp_pkg::out_item_t core_res;

  assign b_ready    = !res_valid || !res_stall;
  assign fire       = a_valid && b_ready;
  assign byte_stall = a_valid && !b_ready;
  assign pready     = 1'b1;
  assign prdata     = (paddr[2:2] == lmrp_pkg::ADDR_MIN_LOAD) ? {16'd0, min_load_address}
                                                               : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_load_address <= lmrp_pkg::MIN_LOAD_RESET;
    end else if (psel && penable && pwrite && paddr[2:2] == lmrp_pkg::ADDR_MIN_LOAD) begin
      min_load_address <= pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!byte_stall) begin
      a_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      a_item <= byte_item;
    end
  end

  lmrp_core u_core (
    .clk              (clk),
    .rst              (rst),
    .fire             (fire),
    .item             (a_item),
    .min_load_address (min_load_address),
    .res              (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (b_ready) begin
      res_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_item <= core_res;
    end
  end

endmodule
